// ===== design/nfa_closure_and_move_engine_assert.svh =====
// Assertion macros for the NFA closure and move engine.
// No dependencies; included by the top level.
`ifndef NFA_CLOSURE_AND_MOVE_ENGINE_ASSERT_SVH
`define NFA_CLOSURE_AND_MOVE_ENGINE_ASSERT_SVH
`ifndef ASSERT_OFF
`define ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define ASSERT_SAME(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ===== design/nfacm_pkg.sv =====
// Types and codes of the NFA closure and move engine.
// No dependencies.
package nfacm_pkg;
   localparam logic [2:0] OP_WR_ENTRY = 3'd0;
   localparam logic [2:0] OP_WR_CLASS = 3'd1;
   localparam logic [2:0] OP_LOAD     = 3'd2;
   localparam logic [2:0] OP_CLOSURE  = 3'd3;
   localparam logic [2:0] OP_MOVE     = 3'd4;

   localparam logic [1:0] KIND_SYMBOL  = 2'd0;
   localparam logic [1:0] KIND_EPSILON = 2'd1;
   localparam logic [1:0] KIND_CLASS   = 2'd2;

   typedef struct packed {
      logic [2:0]  op;
      logic [5:0]  state_index;
      logic [1:0]  edge_kind;
      logic [7:0]  symbol;
      logic [5:0]  first_next;
      logic        first_next_valid;
      logic [5:0]  second_next;
      logic        second_next_valid;
      logic        is_accepting;
      logic [1:0]  word_index;
      logic [63:0] data_word;
   } req_type;

   typedef struct packed {
      logic [63:0] set_bits;
      logic        set_empty;
      logic        accept_found;
      logic [5:0]  accept_state;
   } rsp_type;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] sym;
      logic       v2;
      logic [5:0] n2;
      logic       v1;
      logic [5:0] n1;
   } entry_type;
endpackage

// ===== design/nfacm_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module nfacm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

// ===== design/nfa_closure_and_move_engine.sv =====
// NFA closure and move engine: table writes, set load, epsilon closure, move.
// Closure sweeps all STATE_COUNT states per pass, repeating passes until the set
// stops changing; move sweeps min(states_in_use, STATE_COUNT) states (none when 0).
// One item at a time; the entry RAM read port sets the pace (one state a cycle).
// Synchronous reset clears the set and accepting marks and sets states_in_use to 64;
// table RAMs are not cleared.
module nfa_closure_and_move_engine
   import nfacm_pkg::*;
#(
   parameter int STATE_COUNT = 64,
   parameter int CLASS_WORDS = 4
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  req_type    req_data,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output rsp_type    rsp_data,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [6:0] csr_data
);
`include "nfa_closure_and_move_engine_assert.svh"

   localparam int SC   = STATE_COUNT;
   localparam int IW   = $clog2(SC);
   localparam int CAW  = $clog2(SC * CLASS_WORDS);
   localparam int CNTW = $clog2(SC + 1);

   typedef enum logic [1:0] {S_IDLE, S_CLOS, S_MOVE} state_type;

   state_type        state_ff, state_in;
   logic [SC-1:0]    set_ff, set_in;
   logic [SC-1:0]    acc_ff, acc_in;
   logic [SC-1:0]    next_ff, next_in;
   logic [6:0]       siu_ff;
   logic [CNTW-1:0]  cnt_ff, cnt_in, lim_ff, lim_in;
   logic             issuing_ff, issuing_in;
   logic             pv_ff, pv_in, plast_ff, plast_in;
   logic [IW-1:0]    pidx_ff, pidx_in;
   logic             changed_ff, changed_in;
   logic             found_ff, found_in;
   logic [IW-1:0]    ast_ff, ast_in;
   logic [7:0]       sym_ff, sym_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_ff, rsp_in;

   logic             ent_we, cls_we;
   logic [IW-1:0]    ent_waddr, ent_raddr;
   logic [CAW-1:0]   cls_waddr, cls_raddr;
   entry_type        ent_wdata, ent_rd;
   logic [63:0]      cls_rd;
   logic [23:0]      ent_rd_raw;

   logic             req_fire, finish, fin_found, member, match, word_ok;
   logic [IW-1:0]    fin_state;
   logic [SC-1:0]    tgt;
   logic [CNTW-1:0]  limit;

   nfacm_ram #(.WIDTH(24), .DEPTH(SC)) u_entry_ram (
      .clock(clock), .wr_en(ent_we), .wr_addr(ent_waddr), .wr_data(ent_wdata),
      .rd_addr(ent_raddr), .rd_data(ent_rd_raw)
   );

   nfacm_ram #(.WIDTH(64), .DEPTH(SC * CLASS_WORDS)) u_class_ram (
      .clock(clock), .wr_en(cls_we), .wr_addr(cls_waddr), .wr_data(req_data.data_word),
      .rd_addr(cls_raddr), .rd_data(cls_rd)
   );

   assign ent_rd    = entry_type'(ent_rd_raw);
   assign req_stall = (state_ff != S_IDLE) || (rsp_valid_ff && rsp_stall);
   assign req_fire  = req_valid && !req_stall;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   assign ent_raddr = cnt_ff[IW-1:0];
   assign cls_raddr = CAW'(int'(cnt_ff[IW-1:0]) * CLASS_WORDS + int'(sym_ff[7:6]));
   assign ent_waddr = req_data.state_index[IW-1:0];
   assign cls_waddr = CAW'(int'(req_data.state_index[IW-1:0]) * CLASS_WORDS
                           + int'(req_data.word_index));
   assign limit     = (siu_ff > 7'(SC)) ? CNTW'(SC) : CNTW'(siu_ff);

   always_comb begin
      ent_wdata = '0;
      ent_wdata.kind = req_data.edge_kind;
      ent_wdata.sym  = req_data.symbol;
      if (req_data.first_next_valid && (int'(req_data.first_next) < SC)) begin
         ent_wdata.v1 = 1'b1;
         ent_wdata.n1 = req_data.first_next;
      end
      if (req_data.second_next_valid && (int'(req_data.second_next) < SC)) begin
         ent_wdata.v2 = 1'b1;
         ent_wdata.n2 = req_data.second_next;
      end
   end

   always_comb begin
      state_in     = state_ff;
      set_in       = set_ff;
      acc_in       = acc_ff;
      next_in      = next_ff;
      cnt_in       = cnt_ff;
      lim_in       = lim_ff;
      issuing_in   = issuing_ff;
      pv_in        = 1'b0;
      plast_in     = 1'b0;
      pidx_in      = pidx_ff;
      changed_in   = changed_ff;
      found_in     = found_ff;
      ast_in       = ast_ff;
      sym_in       = sym_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      ent_we       = 1'b0;
      cls_we       = 1'b0;
      finish       = 1'b0;
      fin_found    = 1'b0;
      fin_state    = '0;
      member       = set_ff[pidx_ff];
      tgt          = '0;
      match        = 1'b0;
      word_ok      = ({1'b0, sym_ff[7:6]} < 3'(CLASS_WORDS));

      if (issuing_ff) begin
         pv_in    = 1'b1;
         pidx_in  = cnt_ff[IW-1:0];
         plast_in = (cnt_ff == CNTW'(lim_ff - 1'b1));
         if (plast_in) begin
            issuing_in = 1'b0;
         end else begin
            cnt_in = cnt_ff + 1'b1;
         end
      end

      unique case (state_ff)
         S_IDLE: begin
            issuing_in = 1'b0;
            pv_in      = 1'b0;
            if (req_fire) begin
               case (req_data.op)
                  OP_WR_ENTRY: begin
                     finish = 1'b1;
                     if (int'(req_data.state_index) < SC) begin
                        ent_we = 1'b1;
                        acc_in[req_data.state_index[IW-1:0]] = req_data.is_accepting;
                     end
                  end
                  OP_WR_CLASS: begin
                     finish = 1'b1;
                     cls_we = (int'(req_data.state_index) < SC)
                              && (int'(req_data.word_index) < CLASS_WORDS);
                  end
                  OP_LOAD: begin
                     finish = 1'b1;
                     set_in = req_data.data_word[SC-1:0];
                  end
                  OP_CLOSURE: begin
                     state_in   = S_CLOS;
                     issuing_in = 1'b1;
                     cnt_in     = '0;
                     lim_in     = CNTW'(SC);
                     changed_in = 1'b0;
                     found_in   = 1'b0;
                     ast_in     = '0;
                  end
                  OP_MOVE: begin
                     sym_in = req_data.symbol;
                     if (limit == '0) begin
                        finish = 1'b1;
                        set_in = '0;
                     end else begin
                        state_in   = S_MOVE;
                        issuing_in = 1'b1;
                        cnt_in     = '0;
                        lim_in     = limit;
                        next_in    = '0;
                     end
                  end
                  default: finish = 1'b1;
               endcase
            end
         end
         S_CLOS: begin
            if (pv_ff) begin
               if (member && ent_rd.kind == KIND_EPSILON) begin
                  if (ent_rd.v1) tgt = tgt | (SC'(1) << ent_rd.n1);
                  if (ent_rd.v2) tgt = tgt | (SC'(1) << ent_rd.n2);
               end
               set_in = set_ff | tgt;
               if (set_in != set_ff) changed_in = 1'b1;
               if (member && acc_ff[pidx_ff] && !found_ff) begin
                  found_in = 1'b1;
                  ast_in   = pidx_ff;
               end
               if (plast_ff) begin
                  if (changed_in) begin
                     issuing_in = 1'b1;
                     cnt_in     = '0;
                     changed_in = 1'b0;
                     found_in   = 1'b0;
                     ast_in     = '0;
                  end else begin
                     finish    = 1'b1;
                     fin_found = found_in;
                     fin_state = ast_in;
                     state_in  = S_IDLE;
                  end
               end
            end
         end
         S_MOVE: begin
            if (pv_ff) begin
               if (ent_rd.kind == KIND_SYMBOL) begin
                  match = (ent_rd.sym == sym_ff);
               end else if (ent_rd.kind == KIND_CLASS) begin
                  match = word_ok && cls_rd[sym_ff[5:0]];
               end
               if (member && match && ent_rd.v1) begin
                  next_in = next_ff | (SC'(1) << ent_rd.n1);
               end
               if (plast_ff) begin
                  set_in   = next_in;
                  finish   = 1'b1;
                  state_in = S_IDLE;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase

      if (finish) begin
         rsp_valid_in        = 1'b1;
         rsp_in.set_bits     = 64'(set_in);
         rsp_in.set_empty    = (set_in == '0);
         rsp_in.accept_found = fin_found;
         rsp_in.accept_state = 6'(fin_state);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         set_ff       <= '0;
         acc_ff       <= '0;
         siu_ff       <= 7'd64;
         issuing_ff   <= 1'b0;
         pv_ff        <= 1'b0;
         plast_ff     <= 1'b0;
         changed_ff   <= 1'b0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         set_ff       <= set_in;
         acc_ff       <= acc_in;
         issuing_ff   <= issuing_in;
         pv_ff        <= pv_in;
         plast_ff     <= plast_in;
         changed_ff   <= changed_in;
         found_ff     <= found_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) siu_ff <= csr_data;
      end
      next_ff <= next_in;
      cnt_ff  <= cnt_in;
      lim_ff  <= lim_in;
      pidx_ff <= pidx_in;
      ast_ff  <= ast_in;
      sym_ff  <= sym_in;
      rsp_ff  <= rsp_in;
   end

   `ASSERT_SAME(a_busy_stalls, clock, reset, state_ff != S_IDLE, req_stall)
   `ASSERT_NEXT(a_closure_starts, clock, reset, req_fire && req_data.op == OP_CLOSURE,
                state_ff == S_CLOS)
   `ASSERT_SAME(a_empty_flag, clock, reset, rsp_valid_ff,
                rsp_ff.set_empty == (rsp_ff.set_bits == 64'd0))
   `ASSERT_SAME(a_no_accept_zero, clock, reset, rsp_valid_ff && !rsp_ff.accept_found,
                rsp_ff.accept_state == 6'd0)
endmodule

// ===== tb/nfa_closure_and_move_engine_checker.sv =====
// Checker for the NFA closure and move engine: watches the request, response
// and csr channels, predicts every response and compares it field by field.
// Depends on nfacm_pkg.
`timescale 1ns / 100ps
module nfa_closure_and_move_engine_checker
   import nfacm_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_stall,
   input  req_type    req_data,
   input  logic       rsp_valid,
   input  logic       rsp_stall,
   input  rsp_type    rsp_data,
   input  logic       csr_valid,
   input  logic       csr_ready,
   input  logic [6:0] csr_data,
   output int         mismatches,
   output int         outstanding
);
   logic [1:0]  kind_tbl [64];
   logic [7:0]  sym_tbl [64];
   logic [5:0]  next1_tbl [64];
   logic        next1_ok [64];
   logic [5:0]  next2_tbl [64];
   logic        next2_ok [64];
   logic [63:0] class_tbl [64][4];
   logic [63:0] accept_marks;
   logic [63:0] cur_set;
   logic [6:0]  states_in_use;
   rsp_type     expected_rsp [$];

   function logic [63:0] epsilon_reach(input logic [63:0] s);
      logic [63:0] add;
      add = '0;
      for (int i = 0; i < 64; i++)
         if (s[i] && kind_tbl[i] == KIND_EPSILON) begin
            if (next1_ok[i]) add[next1_tbl[i]] = 1'b1;
            if (next2_ok[i]) add[next2_tbl[i]] = 1'b1;
         end
      return add;
   endfunction

   function rsp_type nfa_step(input req_type r);
      rsp_type     res;
      logic [63:0] grown, hit, nxt;
      int          lim;
      logic        match;
      res = '0;
      case (r.op)
         OP_WR_ENTRY: begin
            kind_tbl[r.state_index]  = r.edge_kind;
            sym_tbl[r.state_index]   = r.symbol;
            next1_tbl[r.state_index] = r.first_next;
            next1_ok[r.state_index]  = r.first_next_valid;
            next2_tbl[r.state_index] = r.second_next;
            next2_ok[r.state_index]  = r.second_next_valid;
            accept_marks[r.state_index] = r.is_accepting;
         end
         OP_WR_CLASS: class_tbl[r.state_index][r.word_index] = r.data_word;
         OP_LOAD:     cur_set = r.data_word;
         OP_CLOSURE: begin
            for (int p = 0; p < 64; p++) begin
               grown = cur_set | epsilon_reach(cur_set);
               if (grown == cur_set) break;
               cur_set = grown;
            end
            hit = cur_set & accept_marks;
            for (int i = 0; i < 64; i++)
               if (hit[i]) begin
                  res.accept_found = 1'b1;
                  res.accept_state = i[5:0];
                  break;
               end
         end
         OP_MOVE: begin
            lim = (states_in_use > 64) ? 64 : int'(states_in_use);
            nxt = '0;
            for (int i = 0; i < lim; i++) begin
               if (!cur_set[i]) continue;
               if (kind_tbl[i] == KIND_SYMBOL)
                  match = (sym_tbl[i] == r.symbol);
               else if (kind_tbl[i] == KIND_CLASS)
                  match = class_tbl[i][r.symbol[7:6]][r.symbol[5:0]];
               else
                  match = 1'b0;
               if (match && next1_ok[i]) nxt[next1_tbl[i]] = 1'b1;
            end
            cur_set = nxt;
         end
         default: ;
      endcase
      res.set_bits  = cur_set;
      res.set_empty = (cur_set == '0);
      return res;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      int      errs;
      errs = 0;
      if (reset) begin
         accept_marks  = '0;
         cur_set       = '0;
         states_in_use = 7'd64;
         expected_rsp.delete();
         mismatches    <= 0;
      end else begin
         if (csr_valid && csr_ready) states_in_use = csr_data;
         if (rsp_valid && !rsp_stall) begin
            if (expected_rsp.size() == 0) begin
               $error("response transfer with nothing expected: %h", rsp_data);
               errs++;
            end else begin
               want = expected_rsp.pop_front();
               if (rsp_data.set_bits !== want.set_bits) begin
                  $error("set_bits expected %h actual %h", want.set_bits, rsp_data.set_bits);
                  errs++;
               end
               if (rsp_data.set_empty !== want.set_empty) begin
                  $error("set_empty expected %b actual %b",
                         want.set_empty, rsp_data.set_empty);
                  errs++;
               end
               if (rsp_data.accept_found !== want.accept_found) begin
                  $error("accept_found expected %b actual %b",
                         want.accept_found, rsp_data.accept_found);
                  errs++;
               end
               if (rsp_data.accept_state !== want.accept_state) begin
                  $error("accept_state expected %0d actual %0d",
                         want.accept_state, rsp_data.accept_state);
                  errs++;
               end
            end
         end
         if (req_valid && !req_stall) expected_rsp.push_back(nfa_step(req_data));
         mismatches <= mismatches + errs;
      end
      outstanding <= expected_rsp.size();
   end
endmodule

// ===== tb/nfa_closure_and_move_engine_tb.sv =====
// Testbench top for the NFA closure and move engine: clock, reset, request
// stimulus, response stall, csr writes and verdict. Depends on nfacm_pkg,
// nfa_closure_and_move_engine and nfa_closure_and_move_engine_checker.
`timescale 1ns / 100ps
module nfa_closure_and_move_engine_tb;
   import nfacm_pkg::*;

   localparam logic [2:0] OP_SPARE_FIRST = 3'd5;
   localparam logic [2:0] OP_SPARE_LAST  = 3'd7;
   localparam logic [1:0] KIND_SPARE     = 2'd3;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   req_type    req_data = '0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   rsp_type    rsp_data;
   logic       csr_valid = 1'b0;
   logic       csr_ready;
   logic [6:0] csr_data = '0;
   int         mismatches;
   int         outstanding;
   bit         calm = 1'b0;
   bit         hold_rsp = 1'b0;
   logic [7:0] sym_hint [64];

   always #5 clock = ~clock;

   nfa_closure_and_move_engine dut (
      .clock, .reset, .req_valid, .req_stall, .req_data,
      .rsp_valid, .rsp_stall, .rsp_data, .csr_valid, .csr_ready, .csr_data
   );

   nfa_closure_and_move_engine_checker checker_i (
      .clock, .reset, .req_valid, .req_stall, .req_data,
      .rsp_valid, .rsp_stall, .rsp_data, .csr_valid, .csr_ready, .csr_data,
      .mismatches, .outstanding
   );

   initial begin
      #200_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // response side stalls
   initial begin
      forever begin
         @(posedge clock);
         if (hold_rsp) begin
            rsp_stall <= 1'b1;
            repeat (400) @(posedge clock);
            rsp_stall <= 1'b0;
            hold_rsp = 1'b0;
         end else if (!calm && $urandom_range(0, 5) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 16)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   function req_type random_req(input logic [2:0] op);
      logic [127:0] raw;
      req_type      r;
      raw = {$urandom(), $urandom(), $urandom(), $urandom()};
      r = raw[$bits(req_type)-1:0];
      r.op = op;
      return r;
   endfunction

   task automatic send(input req_type r);
      if (!calm && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      if (r.op == OP_WR_ENTRY) sym_hint[r.state_index] = r.symbol;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic write_entry(input logic [5:0] idx, input logic [1:0] kind);
      req_type r;
      r = random_req(OP_WR_ENTRY);
      r.state_index = idx;
      r.edge_kind = kind;
      r.first_next_valid = ($urandom_range(0, 5) != 0);
      send(r);
   endtask

   task automatic load_set(input logic [63:0] bits);
      req_type r;
      r = random_req(OP_LOAD);
      r.data_word = bits;
      send(r);
   endtask

   task automatic move_on(input logic [7:0] sym);
      req_type r;
      r = random_req(OP_MOVE);
      r.symbol = sym;
      send(r);
   endtask

   task automatic set_states_in_use(input logic [6:0] v);
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= v;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   task automatic random_traffic(input int n);
      int      pick;
      req_type r;
      for (int k = 0; k < n; k++) begin
         pick = $urandom_range(0, 99);
         if (pick < 15) begin
            write_entry(6'($urandom_range(0, 63)), 2'($urandom_range(0, 3)));
         end else if (pick < 25) begin
            send(random_req(OP_WR_CLASS));
         end else if (pick < 28) begin
            send(random_req(3'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST))));
         end else if (pick < 32) begin
            send(random_req(3'($urandom_range(OP_LOAD, OP_MOVE))));
         end else begin
            // load, closure, then a few moves each followed by a closure
            if ($urandom_range(0, 1))
               load_set({$urandom(), $urandom()} & {$urandom(), $urandom()}
                        & {$urandom(), $urandom()});
            else
               load_set(64'd1 << $urandom_range(0, 63));
            send(random_req(OP_CLOSURE));
            repeat ($urandom_range(1, 3)) begin
               if ($urandom_range(0, 9) < 7)
                  move_on(sym_hint[$urandom_range(0, 63)]);
               else
                  move_on(8'($urandom()));
               send(random_req(OP_CLOSURE));
               k += 2;
            end
            k += 2;
         end
      end
   endtask

   initial begin
      logic [6:0] siu_list [6];
      req_type    r;
      siu_list = '{7'd64, 7'd1, 7'd0, 7'd127, 7'd33, 7'd0};
      siu_list[5] = 7'($urandom_range(2, 63));
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      set_states_in_use(siu_list[0]);

      // fill the whole table so that no entry or class word is read unwritten
      for (int i = 0; i < 64; i++)
         write_entry(6'(i), 2'($urandom_range(0, 3)));
      for (int i = 0; i < 64; i++)
         for (int w = 0; w < 4; w++) begin
            r = random_req(OP_WR_CLASS);
            r.state_index = 6'(i);
            r.word_index = 2'(w);
            send(r);
         end

      // directed: epsilon chain 0..62, an accepting state 63 and a class edge from 1 to 63
      for (int i = 0; i < 62; i++) begin
         r = random_req(OP_WR_ENTRY);
         r.state_index = 6'(i);
         r.edge_kind = KIND_EPSILON;
         r.first_next = 6'(i + 1);
         r.first_next_valid = 1'b1;
         r.second_next = 6'd63;
         r.second_next_valid = 1'b0;
         r.is_accepting = 1'b0;
         send(r);
      end
      r = random_req(OP_WR_ENTRY);
      r.state_index = 6'd63;
      r.edge_kind = KIND_SPARE;
      r.is_accepting = 1'b1;
      send(r);
      r = random_req(OP_WR_ENTRY);
      r.state_index = 6'd1;
      r.edge_kind = KIND_CLASS;
      r.first_next = 6'd63;
      r.first_next_valid = 1'b1;
      send(r);
      r = random_req(OP_WR_CLASS);
      r.state_index = 6'd1;
      r.word_index = 2'd3;
      r.data_word = '1;
      send(r);
      load_set(64'd1);
      send(random_req(OP_CLOSURE));
      move_on(8'd255);
      send(random_req(OP_CLOSURE));
      load_set('1);
      send(random_req(OP_CLOSURE));
      move_on(8'd0);
      load_set('0);
      send(random_req(OP_CLOSURE));
      move_on(8'd128);
      for (int op = OP_SPARE_FIRST; op <= OP_SPARE_LAST; op++)
         send(random_req(3'(op)));

      for (int ph = 1; ph < 6; ph++) begin
         set_states_in_use(siu_list[ph]);
         if (ph == 2) begin
            hold_rsp = 1'b1;
            repeat (30) send(random_req(OP_LOAD));
         end
         if (ph == 5) calm = 1'b1;
         random_traffic(ph == 5 ? 30 : 60);
      end

      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (mismatches == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end
endmodule

// ===== sim.f =====
+incdir+design
design/nfacm_pkg.sv
design/nfacm_ram.sv
design/nfa_closure_and_move_engine.sv
tb/nfa_closure_and_move_engine_checker.sv
tb/nfa_closure_and_move_engine_tb.sv
